// ----- sv/gcd_pkg.sv -----
// shared constants and types of the gcd and lcm unit
package gcd_pkg;

  localparam int unsigned OPERAND_BITS  = 31;
  localparam int unsigned MULTIPLE_BITS = 2 * OPERAND_BITS;
  localparam int unsigned CNT_BITS      = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0]  operand_t;
  typedef logic [MULTIPLE_BITS-1:0] multiple_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;

  localparam cnt_t CNT_LAST = CNT_BITS'(OPERAND_BITS - 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul_step;
    logic res_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_zero;
    logic gcd_eq;
    logic cnt_last;
  } sts_t;

endpackage

// ----- sv/gcd_if.sv -----
// handshake channels of the gcd and lcm unit
interface gcd_in_if;
  logic              valid;
  logic              ready;
  gcd_pkg::operand_t operand_a;
  gcd_pkg::operand_t operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface gcd_out_if;
  logic               valid;
  logic               ready;
  gcd_pkg::operand_t  divisor_result;
  gcd_pkg::multiple_t multiple_result;
  logic               invalid;

  modport source (output valid, output divisor_result, output multiple_result,
                  output invalid, input ready);
  modport sink   (input valid, input divisor_result, input multiple_result,
                  input invalid, output ready);
endinterface

// ----- sv/gcd_ctrl.sv -----
// controller state machine of the gcd and lcm unit
module gcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gcd_pkg::sts_t sts_i,
  output gcd_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GCD  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_zero ? ST_DONE : ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts_i.gcd_eq) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_last) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/gcd_dp.sv -----
// datapath of the gcd and lcm unit: binary gcd, restoring divide, shift-add multiply
module gcd_dp (
  input  logic               clk_i,
  input  gcd_pkg::cmd_t      cmd_i,
  input  gcd_pkg::operand_t  operand_a_i,
  input  gcd_pkg::operand_t  operand_b_i,
  output gcd_pkg::sts_t      sts_o,
  output gcd_pkg::operand_t  divisor_result_o,
  output gcd_pkg::multiple_t multiple_result_o,
  output logic               invalid_o
);

  localparam int unsigned OB = gcd_pkg::OPERAND_BITS;

  gcd_pkg::operand_t  a_q, a_d, b_q, b_d;
  gcd_pkg::operand_t  x_q, x_d, y_q, y_d;
  gcd_pkg::operand_t  g_q, g_d, rem_q, rem_d, quo_q, quo_d;
  gcd_pkg::multiple_t prod_q, prod_d;
  gcd_pkg::cnt_t      k_q, k_d, cnt_q, cnt_d;
  logic               inv_q, inv_d;
  gcd_pkg::operand_t  res_div_q, res_div_d;
  gcd_pkg::multiple_t res_mult_q, res_mult_d;
  logic               res_inv_q, res_inv_d;

  logic [OB:0]        rem_sh;
  logic               ge;
  logic [OB:0]        msum;

  assign sts_o.in_zero  = (operand_a_i == '0) || (operand_b_i == '0);
  assign sts_o.gcd_eq   = (x_q == y_q);
  assign sts_o.cnt_last = (cnt_q == gcd_pkg::CNT_LAST);

  assign divisor_result_o  = res_div_q;
  assign multiple_result_o = res_mult_q;
  assign invalid_o         = res_inv_q;

  // one restoring divide step: shift in the next dividend bit, trial subtract
  assign rem_sh = {rem_q, quo_q[OB-1]};
  assign ge     = (rem_sh >= {1'b0, g_q});
  // one shift-add multiply step on the upper half
  assign msum   = {1'b0, prod_q[2*OB-1:OB]} + (prod_q[0] ? {1'b0, b_q} : '0);

  always_comb begin
    a_d        = a_q;
    b_d        = b_q;
    x_d        = x_q;
    y_d        = y_q;
    k_d        = k_q;
    g_d        = g_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    prod_d     = prod_q;
    cnt_d      = cnt_q;
    inv_d      = inv_q;
    res_div_d  = res_div_q;
    res_mult_d = res_mult_q;
    res_inv_d  = res_inv_q;

    if (cmd_i.load) begin
      a_d   = operand_a_i;
      b_d   = operand_b_i;
      x_d   = operand_a_i;
      y_d   = operand_b_i;
      k_d   = '0;
      inv_d = sts_o.in_zero;
    end

    if (cmd_i.gcd_step) begin
      if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + gcd_pkg::cnt_t'(1);
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q > y_q) begin
        x_d = x_q - y_q;
      end else begin
        y_d = y_q - x_q;
      end
    end

    if (cmd_i.div_init) begin
      g_d   = x_q << k_q;
      rem_d = '0;
      quo_d = a_q;
      cnt_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d = ge ? OB'(rem_sh - {1'b0, g_q}) : rem_sh[OB-1:0];
      quo_d = {quo_q[OB-2:0], ge};
      if (sts_o.cnt_last) begin
        // quotient complete: seed the multiplier with it
        prod_d = {{OB{1'b0}}, quo_q[OB-2:0], ge};
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + gcd_pkg::cnt_t'(1);
      end
    end

    if (cmd_i.mul_step) begin
      prod_d = {msum, prod_q[OB-1:1]};
      cnt_d  = cnt_q + gcd_pkg::cnt_t'(1);
    end

    if (cmd_i.res_load) begin
      res_div_d  = inv_q ? '0 : g_q;
      res_mult_d = inv_q ? '0 : prod_q;
      res_inv_d  = inv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    x_q        <= x_d;
    y_q        <= y_d;
    k_q        <= k_d;
    g_q        <= g_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    prod_q     <= prod_d;
    cnt_q      <= cnt_d;
    inv_q      <= inv_d;
    res_div_q  <= res_div_d;
    res_mult_q <= res_mult_d;
    res_inv_q  <= res_inv_d;
  end

endmodule

// ----- sv/gcd_and_lcm_unit.sv -----
// top level of the gcd and lcm unit
//
//   channel  dir  payload                                          handshake
//   in_i     in   operand_a, operand_b                             valid/ready
//   out_o    out  divisor_result, multiple_result, invalid         valid/ready
//
// one pair at a time: gcd by binary steps (one per cycle), then a restoring divide for
// a/gcd, then a shift-add multiply of that quotient by b, then the result is posted
// a zero operand skips the arithmetic: the controller goes from idle straight to done,
// which posts an invalid result
// the result sits in an output register, so a new pair is taken while it waits
// async active-low reset clears the controller only; no clearing pass
module gcd_and_lcm_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  gcd_in_if.sink    in_i,
  gcd_out_if.source out_o
);

  gcd_pkg::cmd_t cmd;
  gcd_pkg::sts_t sts;

  gcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gcd_dp u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .operand_a_i       (in_i.operand_a),
    .operand_b_i       (in_i.operand_b),
    .sts_o             (sts),
    .divisor_result_o  (out_o.divisor_result),
    .multiple_result_o (out_o.multiple_result),
    .invalid_o         (out_o.invalid)
  );

endmodule

// ----- sv/gcd_chk.sv -----
// port-level assertions of the gcd and lcm unit and their bind
module gcd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input gcd_pkg::operand_t  divisor_i,
  input gcd_pkg::multiple_t multiple_i,
  input logic               invalid_i
);

  // a posted result waits until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction dropped while stalled");

  // invalid results carry zero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && invalid_i |-> divisor_i == '0 && multiple_i == '0)
    else $error("invalid result with nonzero values");

  // valid pairs give a nonzero gcd and an lcm no smaller than it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !invalid_i |->
      divisor_i != '0 && multiple_i >= gcd_pkg::multiple_t'(divisor_i))
    else $error("bad gcd or lcm on a valid pair");

  // one pair in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a pair is in work");

endmodule

bind gcd_and_lcm_unit gcd_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .divisor_i   (out_o.divisor_result),
  .multiple_i  (out_o.multiple_result),
  .invalid_i   (out_o.invalid)
);
